// ----- hw/rtl/ptom_pkg.sv -----
// Shared types and constants for the price-time order matching book.
package ptom_pkg;

   localparam int DefaultBookDepth = 16;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_SELL_IGN  = 2'd2;

   // Request actions.
   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_MATCH = 1'b1;
   localparam logic SIDE_BUY     = 1'b0;
   localparam logic SIDE_SELL    = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] order_id;
      logic        side;
      logic [23:0] price;
      logic [19:0] quantity;
   } req_type;

   typedef struct packed {
      logic        trade_valid;
      logic [31:0] maker_id;
      logic [31:0] taker_id;
      logic [23:0] trade_price;
      logic [19:0] trade_quantity;
      logic [19:0] remaining_quantity;
      logic [1:0]  status;
      logic        best_valid;
      logic [31:0] best_id;
      logic [23:0] best_price;
      logic [19:0] best_quantity;
      logic        last;
   } rsp_type;

   // One resting order as held in a cell.
   typedef struct packed {
      logic        used;
      logic [31:0] id;
      logic [23:0] price;
      logic [19:0] quantity;
   } entry_type;

   // Command broadcast from the sequencer to every cell.
   typedef struct packed {
      logic        insert;
      logic        pop;
      logic        set_head_qty;
      logic [19:0] head_qty;
      entry_type   new_entry;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH
   } state_type;

endpackage

// ----- hw/rtl/ptom_cell.sv -----
// One book slot: holds an order and shifts with its neighbors on insert or pop.
module ptom_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ptom_pkg::cell_cmd_type cmd,
   input  ptom_pkg::entry_type   prev_entry,
   input  ptom_pkg::entry_type   next_entry,
   input  logic                  prev_goes_ahead,
   input  logic                  is_head,
   output ptom_pkg::entry_type   entry,
   output logic                  goes_ahead
);
   import ptom_pkg::*;

   entry_type entry_ff, entry_in;
   logic      used_ff, used_in;

   // The new order lands behind every order of equal or higher price.
   assign goes_ahead = used_ff && (entry_ff.price >= cmd.new_entry.price);

   always_comb begin
      entry_in      = entry_ff;
      entry_in.used = used_ff;
      if (cmd.insert) begin
         if (!goes_ahead) begin
            entry_in = prev_goes_ahead ? cmd.new_entry : prev_entry;
         end
      end else if (cmd.pop) begin
         entry_in = next_entry;
      end else if (cmd.set_head_qty && is_head) begin
         entry_in.quantity = cmd.head_qty;
      end
      used_in = entry_in.used;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
      entry_ff <= entry_in;
   end

   always_comb begin
      entry      = entry_ff;
      entry.used = used_ff;
   end
endmodule

// ----- hw/rtl/ptom_ctrl.sv -----
// Sequencer: decodes requests, runs one trade per cycle and forms results.
module ptom_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ptom_pkg::req_type      req_data,
   input  ptom_pkg::entry_type    head,
   input  ptom_pkg::entry_type    second,
   input  logic                   full,
   output logic                   busy,
   output logic                   rsp_strobe,
   output ptom_pkg::rsp_type      rsp_data,
   output ptom_pkg::cell_cmd_type cmd
);
   import ptom_pkg::*;

   state_type   state_ff, state_in;
   logic [31:0] sell_id_ff, sell_id_in;
   logic [23:0] sell_price_ff, sell_price_in;
   logic [19:0] rem_ff, rem_in;
   logic        strobe_ff, strobe_in;
   rsp_type     rsp_ff, rsp_in;
   logic        report_ff, report_in;
   logic [1:0]  rstat_ff, rstat_in;
   logic        rtrade_ff, rtrade_in;
   logic [31:0] rbuyer_ff, rbuyer_in;
   logic [23:0] rtp_ff, rtp_in;
   logic [19:0] rtq_ff, rtq_in;
   logic [19:0] rrem_ff, rrem_in;
   logic        rseller_ff, rseller_in;
   logic        rlast_ff, rlast_in;

   logic        can_trade;
   logic [19:0] tq;
   logic [19:0] rq_left;
   logic [19:0] rem_left;
   logic        head_pops;
   entry_type   after_head;
   logic        more;

   // One trade step against the head cell.
   always_comb begin
      can_trade  = (rem_ff != '0) && head.used && (sell_price_ff <= head.price);
      tq         = (rem_ff < head.quantity) ? rem_ff : head.quantity;
      rq_left    = head.quantity - tq;
      rem_left   = rem_ff - tq;
      head_pops  = (rq_left == '0);
      after_head = head_pops ? second : head;
      if (!head_pops) after_head.quantity = rq_left;
      more = (rem_left != '0) && after_head.used && (sell_price_ff <= after_head.price);
   end

   always_comb begin
      state_in      = state_ff;
      sell_id_in    = sell_id_ff;
      sell_price_in = sell_price_ff;
      rem_in        = rem_ff;
      report_in     = 1'b0;
      rstat_in      = STATUS_OK;
      rtrade_in     = 1'b0;
      rbuyer_in     = '0;
      rtp_in        = '0;
      rtq_in        = '0;
      rrem_in       = '0;
      rseller_in    = 1'b0;
      rlast_in      = 1'b1;
      cmd           = '0;
      cmd.new_entry = '{used: 1'b1, id: req_data.order_id, price: req_data.price,
                        quantity: req_data.quantity};
      busy          = (state_ff != ST_IDLE) || report_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               if (req_data.action == ACTION_ADD) begin
                  report_in = 1'b1;
                  if (req_data.side != SIDE_BUY) begin
                     rstat_in = STATUS_SELL_IGN;
                  end else if (full) begin
                     rstat_in = STATUS_FULL;
                  end else begin
                     cmd.insert = 1'b1;
                  end
               end else begin
                  sell_id_in    = req_data.order_id;
                  sell_price_in = req_data.price;
                  rem_in        = req_data.quantity;
                  state_in      = ST_MATCH;
               end
            end
         end
         ST_MATCH: begin
            report_in  = 1'b1;
            rseller_in = 1'b1;
            if (can_trade) begin
               rtrade_in = 1'b1;
               rbuyer_in = head.id;
               rtp_in    = head.price;
               rtq_in    = tq;
               rrem_in   = rem_left;
               rem_in    = rem_left;
               rlast_in  = !more;
               cmd.pop          = head_pops;
               cmd.set_head_qty = !head_pops;
               cmd.head_qty     = rq_left;
               if (!more) state_in = ST_IDLE;
            end else begin
               rrem_in  = rem_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Results are built in the cycle after the trade so the best fields see the updated book.
   always_comb begin
      rsp_in = '0;
      rsp_in.trade_valid        = rtrade_ff;
      rsp_in.maker_id           = rbuyer_ff;
      rsp_in.taker_id           = rseller_ff ? sell_id_ff : '0;
      rsp_in.trade_price        = rtp_ff;
      rsp_in.trade_quantity     = rtq_ff;
      rsp_in.remaining_quantity = rrem_ff;
      rsp_in.status             = rstat_ff;
      rsp_in.best_valid         = head.used;
      rsp_in.best_id            = head.used ? head.id : '0;
      rsp_in.best_price         = head.used ? head.price : '0;
      rsp_in.best_quantity      = head.used ? head.quantity : '0;
      rsp_in.last               = rlast_ff;
      strobe_in                 = report_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         report_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         report_ff <= report_in;
         strobe_ff <= strobe_in;
      end
      sell_id_ff    <= sell_id_in;
      sell_price_ff <= sell_price_in;
      rem_ff        <= rem_in;
      rstat_ff      <= rstat_in;
      rtrade_ff     <= rtrade_in;
      rbuyer_ff     <= rbuyer_in;
      rtp_ff        <= rtp_in;
      rtq_ff        <= rtq_in;
      rrem_ff       <= rrem_in;
      rseller_ff    <= rseller_in;
      rlast_ff      <= rlast_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
endmodule

// ----- hw/rtl/price_time_order_match.sv -----
// Top level of the price-time priority buy book with sell matching.
//
//  channel   ports                     direction  handshake
//  request   start, busy, req_data     in         taken when start && !busy
//  result    rsp_strobe, rsp_data      out        one strobe per result, no stall
//
// An add's single result passes through report_ff and then rsp_ff to the result ports.
// A match trades once per cycle in the head cell from the cycle after acceptance,
// at most BookDepth trades; each result passes through the report registers and then rsp_ff.
// Reset empties the book at once; slot contents are not cleared.
// busy stays high until the last result of a request is on the result ports.
module price_time_order_match #(
   parameter int BookDepth = ptom_pkg::DefaultBookDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptom_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ptom_pkg::rsp_type rsp_data
);
   import ptom_pkg::*;

   cell_cmd_type cmd;
   entry_type    entries [BookDepth];
   logic         ahead   [BookDepth];
   entry_type    empty_entry;

   assign empty_entry = '0;

   // Row of cells; cell 0 holds the best order and has nothing ahead of it.
   for (genvar g = 0; g < BookDepth; g++) begin : g_cell
      ptom_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cmd),
         .prev_entry     ((g == 0) ? empty_entry : entries[(g == 0) ? 0 : g - 1]),
         .next_entry     ((g == BookDepth - 1) ? empty_entry
                                               : entries[(g == BookDepth - 1) ? g : g + 1]),
         .prev_goes_ahead((g == 0) ? 1'b1 : ahead[(g == 0) ? 0 : g - 1]),
         .is_head        (g == 0),
         .entry          (entries[g]),
         .goes_ahead     (ahead[g])
      );
   end

   ptom_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .head      (entries[0]),
      .second    (entries[1]),
      .full      (entries[BookDepth - 1].used),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .cmd       (cmd)
   );

   // A pop and an insert never happen in the same cycle.
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && (cmd.pop || cmd.set_head_qty)))
      else $error("insert overlaps a trade update");

   // An insert happens only on an accepted request.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (busy && cmd.insert) |-> 1'b0)
      else $error("insert while busy");

   // An accepted request raises busy in the next cycle.
   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a request");
endmodule

// ----- sim/tb_price_time_order_match.sv -----
// Self-checking testbench for the price-time priority buy book and sell matcher.
`timescale 1ns / 100ps

module tb_price_time_order_match;
   import ptom_pkg::*;

   localparam int Depth = DefaultBookDepth;
   localparam int CycleLimit = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   price_time_order_match u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   // Shadow copy of the buy book; slot 0 is the best order.
   int          book_count;
   logic [31:0] book_id[Depth];
   logic [23:0] book_price[Depth];
   logic [19:0] book_qty[Depth];

   rsp_type pending_rsp[$];
   int      mismatch_count;
   int      cycle_count;
   bit      quiet_phase;

   // Directed stimulus table; a known result is typed in where the row has one.
   typedef struct {
      req_type req;
      bit      has_known;
      rsp_type known;
   } dir_row_type;

   function automatic rsp_type book_snapshot(rsp_type r);
      r.best_valid    = book_count > 0;
      r.best_id       = book_count > 0 ? book_id[0] : '0;
      r.best_price    = book_count > 0 ? book_price[0] : '0;
      r.best_quantity = book_count > 0 ? book_qty[0] : '0;
      return r;
   endfunction

   // Applies one request to the shadow book and queues the results it causes.
   task automatic predict_request(input req_type rq);
      rsp_type     r;
      int          pos;
      int          trades;
      logic [19:0] left;
      logic [19:0] fill;
      begin
         r = '0;
         if (rq.action == ACTION_ADD) begin
            r.last = 1'b1;
            if (rq.side != SIDE_BUY) begin
               r.status = STATUS_SELL_IGN;
            end else if (book_count >= Depth) begin
               r.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < book_count && book_price[pos] >= rq.price) pos++;
               for (int i = book_count; i > pos; i--) begin
                  book_id[i]    = book_id[i-1];
                  book_price[i] = book_price[i-1];
                  book_qty[i]   = book_qty[i-1];
               end
               book_id[pos] = rq.order_id;
               book_price[pos] = rq.price;
               book_qty[pos] = rq.quantity;
               book_count++;
               r.status = STATUS_OK;
            end
            pending_rsp = {pending_rsp, book_snapshot(r)};
         end else begin
            trades = 0;
            left = rq.quantity;
            while (left > 0 && book_count > 0 && rq.price <= book_price[0]
                   && trades < Depth) begin
               fill = left < book_qty[0] ? left : book_qty[0];
               r = '0;
               r.trade_valid = 1'b1;
               r.maker_id = book_id[0];
               r.taker_id = rq.order_id;
               r.trade_price = book_price[0];
               r.trade_quantity = fill;
               left -= fill;
               r.remaining_quantity = left;
               book_qty[0] -= fill;
               if (book_qty[0] == 0) begin
                  for (int i = 0; i + 1 < book_count; i++) begin
                     book_id[i]    = book_id[i+1];
                     book_price[i] = book_price[i+1];
                     book_qty[i]   = book_qty[i+1];
                  end
                  book_count--;
               end
               r.last = !(left > 0 && book_count > 0 && rq.price <= book_price[0]);
               trades++;
               if (trades == Depth) r.last = 1'b1;
               pending_rsp = {pending_rsp, book_snapshot(r)};
            end
            if (trades == 0) begin
               r = '0;
               r.taker_id = rq.order_id;
               r.remaining_quantity = left;
               r.last = 1'b1;
               pending_rsp = {pending_rsp, book_snapshot(r)};
            end
         end
      end
   endtask

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result checker: compares each strobed result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result %h", rsp_data);
         end else begin
            if (pending_rsp[0] !== rsp_data) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected %h actual %h", pending_rsp[0], rsp_data);
            end
            pending_rsp.delete(0);
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic req_type make_req(logic act, logic [31:0] id, logic sd,
                                        logic [23:0] pr, logic [19:0] qt);
      req_type rq;
      rq.action = act;
      rq.order_id = id;
      rq.side = sd;
      rq.price = pr;
      rq.quantity = qt;
      return rq;
   endfunction

   // Presents one request, holds it until accepted, and predicts its results.
   // start stays high between back-to-back requests and drops only for idling.
   task automatic send_request(input req_type rq);
      int gap;
      begin
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         start <= 1'b1;
         req_data <= rq;
         @(posedge clock);
         while (busy) @(posedge clock);
         predict_request(rq);
      end
   endtask

   // Random request: mostly buy adds and matches near a common price band.
   function automatic req_type random_req();
      logic [23:0] pr;
      logic [19:0] qt;
      int          pick;
      pick = $urandom_range(0, 99);
      pr = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'(1000 + $urandom_range(0, 20));
      qt = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 50));
      if (pick < 8)
         return make_req(ACTION_ADD, $urandom, SIDE_SELL, pr, qt);
      else if (pick < 58)
         return make_req(ACTION_ADD, $urandom, SIDE_BUY, pr, qt);
      else
         return make_req(ACTION_MATCH, $urandom, SIDE_BUY, pr,
                         ($urandom_range(0, 3) == 0) ? 20'($urandom_range(50, 400)) : qt);
   endfunction

   dir_row_type dir_rows[$];

   initial begin
      dir_row_type row;
      rsp_type     k;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      mismatch_count = 0;
      cycle_count = 0;
      quiet_phase = 1'b0;
      book_count = 0;

      // Match on an empty book: no trade, known result.
      row.req = make_req(ACTION_MATCH, 32'hFFFF_FFFF, SIDE_BUY, 24'd0, 20'hFFFFF);
      row.has_known = 1'b1;
      k = '0; k.taker_id = 32'hFFFF_FFFF; k.remaining_quantity = 20'hFFFFF; k.last = 1'b1;
      row.known = k;
      dir_rows = {dir_rows, row};
      // Sell add is ignored with its own status.
      row.req = make_req(ACTION_ADD, 32'h1234_5678, SIDE_SELL, 24'hFFFFFF, 20'hFFFFF);
      k = '0; k.status = STATUS_SELL_IGN; k.last = 1'b1;
      row.known = k;
      dir_rows = {dir_rows, row};
      // Extreme prices and quantities, a zero-quantity buy, then equal prices.
      row.has_known = 1'b0;
      row.req = make_req(ACTION_ADD, 32'hFFFF_FFFF, SIDE_BUY, 24'hFFFFFF, 20'hFFFFF);
      dir_rows = {dir_rows, row};
      row.req = make_req(ACTION_ADD, 32'd0, SIDE_BUY, 24'd0, 20'd0);
      dir_rows = {dir_rows, row};
      for (int i = 0; i < 14; i++) begin
         row.req = make_req(ACTION_ADD, 32'(100 + i), SIDE_BUY, 24'(500 + (i % 3)), 20'(i + 1));
         dir_rows = {dir_rows, row};
      end
      // Book is full now: the next buy is dropped.
      row.req = make_req(ACTION_ADD, 32'hAAAA_5555, SIDE_BUY, 24'd999, 20'd7);
      dir_rows = {dir_rows, row};
      // Zero-quantity sell, then sells at 501 and at price 0 that trade into the book from its best order.
      row.req = make_req(ACTION_MATCH, 32'h5555_AAAA, SIDE_BUY, 24'd0, 20'd0);
      dir_rows = {dir_rows, row};
      row.req = make_req(ACTION_MATCH, 32'd77, SIDE_BUY, 24'd501, 20'd20);
      dir_rows = {dir_rows, row};
      row.req = make_req(ACTION_MATCH, 32'd78, SIDE_SELL, 24'd0, 20'hFFFFF);
      dir_rows = {dir_rows, row};
      row.req = make_req(ACTION_MATCH, 32'd79, SIDE_BUY, 24'd0, 20'd1);
      dir_rows = {dir_rows, row};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].req);
         if (dir_rows[i].has_known && pending_rsp.size() > 0
             && pending_rsp[pending_rsp.size()-1] !== dir_rows[i].known) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Table row %0d: expected %h predicted %h", i,
                        dir_rows[i].known, pending_rsp[pending_rsp.size()-1]);
         end
      end

      // Random part; the sender waits for every result once midway.
      for (int n = 0; n < 330; n++) begin
         if (n == 150) begin
            start <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         if (n == 280) quiet_phase = 1'b1;
         send_request(random_req());
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (Depth + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- price_time_order_match.f -----
hw/rtl/ptom_pkg.sv
hw/rtl/ptom_cell.sv
hw/rtl/ptom_ctrl.sv
hw/rtl/price_time_order_match.sv
sim/tb_price_time_order_match.sv
